// ===== rtl/atp_pkg.sv =====
// Shared constants, types and the arctangent table of the tilt angle pipeline.
`default_nettype none
package atp_pkg;

   // Angle output format.
   localparam int ANGLE_FRAC_BITS = 8;
   localparam int ANGLE_W         = 16;
   localparam int ANGLE_FULL      = 90 << ANGLE_FRAC_BITS;
   localparam int ANGLE_SAT       = 32767;

   // Identification byte of a valid device.
   localparam logic [7:0] ID_VALID = 8'hE5;

   // Sample and square widths.
   localparam int SAMPLE_W = 16;
   localparam int SQ_W     = 31;
   localparam int DEN_W    = 32;

   // Square root: one result bit per stage.
   localparam int SQRT_STEPS = 32;
   localparam int ROOT_W     = 32;
   localparam int REM_W      = 35;

   // Vectoring rotation: one micro-rotation per stage.
   localparam int CORDIC_STEPS = 25;
   localparam int TABLE_SHIFT  = 20;
   localparam int XY_W         = 35;
   localparam int Z_W          = 28;

   // atan(2^-i) in degrees, scaled by 2^20 and rounded.
   localparam logic signed [Z_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
      28'sd47185920, 28'sd27855475, 28'sd14718068, 28'sd7471121, 28'sd3750058,
      28'sd1876857,  28'sd938658,   28'sd469357,   28'sd234682,  28'sd117342,
      28'sd58671,    28'sd29335,    28'sd14668,    28'sd7334,    28'sd3667,
      28'sd1833,     28'sd917,      28'sd458,      28'sd229,     28'sd115,
      28'sd57,       28'sd29,       28'sd14,       28'sd7,       28'sd4
   };

   // Side information that travels with one angle through its lane.
   typedef struct packed {
      logic                id_bad;
      logic                neg;
      logic                num_zero;
      logic                den_zero;
      logic [SAMPLE_W-1:0] num_mag;
   } lane_tag_type;

endpackage
`default_nettype wire

// ===== rtl/atp_if.sv =====
// Handshake interfaces of the snapshot input and the angle result channels.
`default_nettype none
interface atp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] device_id;
   logic [7:0] x_low;
   logic [7:0] x_high;
   logic [7:0] y_low;
   logic [7:0] y_high;
   logic [7:0] z_low;
   logic [7:0] z_high;

   modport source (output valid, device_id, x_low, x_high, y_low, y_high, z_low, z_high,
                   input ready);
   modport sink   (input valid, device_id, x_low, x_high, y_low, y_high, z_low, z_high,
                   output ready);
endinterface

interface atp_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                status;
   logic signed [atp_pkg::ANGLE_W-1:0] pitch_angle;
   logic signed [atp_pkg::ANGLE_W-1:0] roll_angle;

   modport source (output valid, status, pitch_angle, roll_angle, input ready);
   modport sink   (input valid, status, pitch_angle, roll_angle, output ready);
endinterface
`default_nettype wire

// ===== rtl/accel_tilt_pitch_roll.sv =====
// Top level: pitch and roll from one accelerometer snapshot, fully pipelined.
// An accepted request word passes through the join, square and sum stages,
// 32 square root stages, 25 rotation stages and the output register on the way
// to its response word. Throughput is one word per cycle while the response
// side is ready; the longest path is one 35-bit add and compare in a root stage.
// Synchronous active-high reset clears every valid bit; data registers keep
// whatever they held.
`default_nettype none
module accel_tilt_pitch_roll (
   input  wire         clock,
   input  wire         reset,
   atp_req_if.sink     req_if,
   atp_rsp_if.source   rsp_if
);

   localparam int SW = atp_pkg::SAMPLE_W;
   localparam int ZW = atp_pkg::Z_W;
   localparam int AW = atp_pkg::ANGLE_W;
   localparam int F  = atp_pkg::ANGLE_FRAC_BITS;
   localparam int RSH = atp_pkg::TABLE_SHIFT - F;
   localparam logic [ZW:0] ROUND_HALF = (ZW+1)'(1) << (RSH - 1);
   localparam logic [ZW:0] FULL_MAG   = (ZW+1)'(atp_pkg::ANGLE_FULL);
   localparam logic [ZW:0] SAT_MAG    = (ZW+1)'(atp_pkg::ANGLE_SAT);
   localparam logic signed [AW-1:0] FULL_ANGLE = AW'(atp_pkg::ANGLE_FULL);

   // The whole pipeline advances together unless a finished word waits at the
   // output. The output register is the only place a stall is felt, so a new
   // request word is taken in every cycle that the response side drains.
   logic ce;
   logic out_valid_ff;

   assign ce           = !out_valid_ff || rsp_if.ready;
   assign req_if.ready = ce;

   // Stage 1: join the byte pairs into signed samples and check the id.
   logic                 s1_valid_ff;
   logic                 s1_id_bad_ff;
   logic signed [SW-1:0] s1_x_ff;
   logic signed [SW-1:0] s1_y_ff;
   logic signed [SW-1:0] s1_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (ce) begin
         s1_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         s1_id_bad_ff <= (req_if.device_id != atp_pkg::ID_VALID);
         s1_x_ff      <= signed'({req_if.x_high, req_if.x_low});
         s1_y_ff      <= signed'({req_if.y_high, req_if.y_low});
         s1_z_ff      <= signed'({req_if.z_high, req_if.z_low});
      end
   end

   // Stage 2: square each axis and take the magnitudes of the numerators.
   logic                          s2_valid_ff;
   logic                          s2_id_bad_ff;
   logic [atp_pkg::SQ_W-1:0]      s2_xx_ff;
   logic [atp_pkg::SQ_W-1:0]      s2_yy_ff;
   logic [atp_pkg::SQ_W-1:0]      s2_zz_ff;
   logic                          s2_x_neg_ff;
   logic                          s2_y_neg_ff;
   logic                          s2_x_zero_ff;
   logic                          s2_y_zero_ff;
   logic [SW-1:0]                 s2_x_mag_ff;
   logic [SW-1:0]                 s2_y_mag_ff;
   logic signed [2*SW-1:0]        xx_full;
   logic signed [2*SW-1:0]        yy_full;
   logic signed [2*SW-1:0]        zz_full;

   always_comb begin
      xx_full = s1_x_ff * s1_x_ff;
      yy_full = s1_y_ff * s1_y_ff;
      zz_full = s1_z_ff * s1_z_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (ce) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         s2_id_bad_ff <= s1_id_bad_ff;
         s2_xx_ff     <= xx_full[atp_pkg::SQ_W-1:0];
         s2_yy_ff     <= yy_full[atp_pkg::SQ_W-1:0];
         s2_zz_ff     <= zz_full[atp_pkg::SQ_W-1:0];
         s2_x_neg_ff  <= s1_x_ff[SW-1];
         s2_y_neg_ff  <= s1_y_ff[SW-1];
         s2_x_zero_ff <= (s1_x_ff == '0);
         s2_y_zero_ff <= (s1_y_ff == '0);
         s2_x_mag_ff  <= s1_x_ff[SW-1] ? SW'(-s1_x_ff) : SW'(s1_x_ff);
         s2_y_mag_ff  <= s1_y_ff[SW-1] ? SW'(-s1_y_ff) : SW'(s1_y_ff);
      end
   end

   // Stage 3: sum the squares that form each denominator.
   logic                          s3_valid_ff;
   logic [atp_pkg::DEN_W-1:0]     s3_pitch_den_ff;
   logic [atp_pkg::DEN_W-1:0]     s3_roll_den_ff;
   atp_pkg::lane_tag_type         s3_pitch_tag_ff;
   atp_pkg::lane_tag_type         s3_roll_tag_ff;
   logic [atp_pkg::DEN_W-1:0]     pitch_den_in;
   logic [atp_pkg::DEN_W-1:0]     roll_den_in;

   always_comb begin
      pitch_den_in = atp_pkg::DEN_W'(s2_yy_ff) + atp_pkg::DEN_W'(s2_zz_ff);
      roll_den_in  = atp_pkg::DEN_W'(s2_xx_ff) + atp_pkg::DEN_W'(s2_zz_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (ce) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         s3_pitch_den_ff          <= pitch_den_in;
         s3_roll_den_ff           <= roll_den_in;
         s3_pitch_tag_ff.id_bad   <= s2_id_bad_ff;
         s3_pitch_tag_ff.neg      <= s2_x_neg_ff;
         s3_pitch_tag_ff.num_zero <= s2_x_zero_ff;
         s3_pitch_tag_ff.den_zero <= (pitch_den_in == '0);
         s3_pitch_tag_ff.num_mag  <= s2_x_mag_ff;
         s3_roll_tag_ff.id_bad    <= s2_id_bad_ff;
         s3_roll_tag_ff.neg       <= s2_y_neg_ff;
         s3_roll_tag_ff.num_zero  <= s2_y_zero_ff;
         s3_roll_tag_ff.den_zero  <= (roll_den_in == '0);
         s3_roll_tag_ff.num_mag   <= s2_y_mag_ff;
      end
   end

   // Square root of each denominator, scaled by 2^16.
   logic                          sq_valid;
   logic                          sq_roll_valid;
   logic [atp_pkg::ROOT_W-1:0]    sq_pitch_root;
   logic [atp_pkg::ROOT_W-1:0]    sq_roll_root;
   atp_pkg::lane_tag_type         sq_pitch_tag;
   atp_pkg::lane_tag_type         sq_roll_tag;

   atp_sqrt_pipe u_sqrt_pitch (
      .clock     (clock),
      .reset     (reset),
      .ce        (ce),
      .in_valid  (s3_valid_ff),
      .in_den    (s3_pitch_den_ff),
      .in_tag    (s3_pitch_tag_ff),
      .out_valid (sq_valid),
      .out_root  (sq_pitch_root),
      .out_tag   (sq_pitch_tag)
   );

   atp_sqrt_pipe u_sqrt_roll (
      .clock     (clock),
      .reset     (reset),
      .ce        (ce),
      .in_valid  (s3_valid_ff),
      .in_den    (s3_roll_den_ff),
      .in_tag    (s3_roll_tag_ff),
      .out_valid (sq_roll_valid),
      .out_root  (sq_roll_root),
      .out_tag   (sq_roll_tag)
   );

   // Vectoring rotation of (root, |num| * 2^16) gives the angle in degrees.
   logic                          cr_valid;
   logic                          cr_roll_valid;
   logic signed [ZW-1:0]          cr_pitch_z;
   logic signed [ZW-1:0]          cr_roll_z;
   atp_pkg::lane_tag_type         cr_pitch_tag;
   atp_pkg::lane_tag_type         cr_roll_tag;

   atp_cordic_pipe u_cordic_pitch (
      .clock     (clock),
      .reset     (reset),
      .ce        (ce),
      .in_valid  (sq_valid),
      .in_den    (sq_pitch_root),
      .in_tag    (sq_pitch_tag),
      .out_valid (cr_valid),
      .out_z     (cr_pitch_z),
      .out_tag   (cr_pitch_tag)
   );

   atp_cordic_pipe u_cordic_roll (
      .clock     (clock),
      .reset     (reset),
      .ce        (ce),
      .in_valid  (sq_roll_valid),
      .in_den    (sq_roll_root),
      .in_tag    (sq_roll_tag),
      .out_valid (cr_roll_valid),
      .out_z     (cr_roll_z),
      .out_tag   (cr_roll_tag)
   );

   // Output stage: round to the output fraction, clamp, apply the sign and the
   // special cases. A zero numerator gives zero, a zero denominator gives a
   // right angle, and a bad id forces both angles to zero.
   function automatic logic signed [AW-1:0] finish_angle(
      input logic signed [ZW-1:0]   z,
      input atp_pkg::lane_tag_type  tag
   );
      logic [ZW:0] zpos;
      logic [ZW:0] mag;
      logic [AW-1:0] mag16;
      zpos = z[ZW-1] ? '0 : {1'b0, z};
      mag  = (zpos + ROUND_HALF) >> RSH;
      if (tag.den_zero || mag > FULL_MAG) begin
         mag = FULL_MAG;
      end
      if (mag > SAT_MAG) begin
         mag = SAT_MAG;
      end
      mag16 = mag[AW-1:0];
      if (tag.id_bad || tag.num_zero) begin
         finish_angle = '0;
      end else if (tag.neg) begin
         finish_angle = signed'(-mag16);
      end else begin
         finish_angle = signed'(mag16);
      end
   endfunction

   logic                 status_ff;
   logic signed [AW-1:0] pitch_ff;
   logic signed [AW-1:0] roll_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (ce) begin
         out_valid_ff <= cr_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         status_ff <= cr_pitch_tag.id_bad;
         pitch_ff  <= finish_angle(cr_pitch_z, cr_pitch_tag);
         roll_ff   <= finish_angle(cr_roll_z, cr_roll_tag);
      end
   end

   assign rsp_if.valid       = out_valid_ff;
   assign rsp_if.status      = status_ff;
   assign rsp_if.pitch_angle = pitch_ff;
   assign rsp_if.roll_angle  = roll_ff;

   // Both lanes are fed from one set of stage registers and must stay aligned.
   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      cr_valid == cr_roll_valid)
      else $error("pitch and roll lanes out of step");

   // A rejected device id never reports a nonzero angle.
   a_bad_id_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.status |-> rsp_if.pitch_angle == '0 && rsp_if.roll_angle == '0)
      else $error("nonzero angle with id mismatch");

   // A word held at the output blocks new request words in the same cycle.
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.ready |-> !req_if.ready)
      else $error("input taken while output stalled");

   // Angles never exceed a right angle in either direction.
   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> rsp_if.pitch_angle <= FULL_ANGLE
                    && rsp_if.pitch_angle >= -FULL_ANGLE
                    && rsp_if.roll_angle <= FULL_ANGLE
                    && rsp_if.roll_angle >= -FULL_ANGLE)
      else $error("angle beyond right angle");

endmodule
`default_nettype wire

// ===== rtl/atp_sqrt_pipe.sv =====
// Pipelined integer square root of den * 2^32, one root bit per stage.
`default_nettype none
module atp_sqrt_pipe (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              ce,
   input  wire                              in_valid,
   input  wire [atp_pkg::DEN_W-1:0]         in_den,
   input  wire atp_pkg::lane_tag_type       in_tag,
   output logic                             out_valid,
   output logic [atp_pkg::ROOT_W-1:0]       out_root,
   output atp_pkg::lane_tag_type            out_tag
);

   localparam int N = atp_pkg::SQRT_STEPS;

   logic                          valid_ff [N];
   logic [atp_pkg::REM_W-1:0]     rem_ff   [N];
   logic [atp_pkg::ROOT_W-1:0]    root_ff  [N];
   logic [atp_pkg::DEN_W-1:0]     rad_ff   [N];
   atp_pkg::lane_tag_type         tag_ff   [N];

   for (genvar j = 0; j < N; j++) begin : g_stage
      logic                          valid_p;
      logic [atp_pkg::REM_W-1:0]     rem_p;
      logic [atp_pkg::ROOT_W-1:0]    root_p;
      logic [atp_pkg::DEN_W-1:0]     rad_p;
      atp_pkg::lane_tag_type         tag_p;
      logic [atp_pkg::REM_W-1:0]     rem_sh;
      logic [atp_pkg::REM_W-1:0]     trial;
      logic                          ge;
      logic [atp_pkg::REM_W-1:0]     rem_in;
      logic [atp_pkg::ROOT_W-1:0]    root_in;
      logic [atp_pkg::DEN_W-1:0]     rad_in;

      if (j == 0) begin : g_first
         assign valid_p = in_valid;
         assign rem_p   = '0;
         assign root_p  = '0;
         assign rad_p   = in_den;
         assign tag_p   = in_tag;
      end else begin : g_next
         assign valid_p = valid_ff[j-1];
         assign rem_p   = rem_ff[j-1];
         assign root_p  = root_ff[j-1];
         assign rad_p   = rad_ff[j-1];
         assign tag_p   = tag_ff[j-1];
      end

      // Bring down the next two radicand bits and try root*4+1.
      always_comb begin
         rem_sh  = {rem_p[atp_pkg::REM_W-3:0], rad_p[atp_pkg::DEN_W-1 -: 2]};
         trial   = {1'b0, root_p, 2'b01};
         ge      = (rem_sh >= trial);
         rem_in  = ge ? (rem_sh - trial) : rem_sh;
         root_in = {root_p[atp_pkg::ROOT_W-2:0], ge};
         rad_in  = {rad_p[atp_pkg::DEN_W-3:0], 2'b00};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (ce) begin
            valid_ff[j] <= valid_p;
         end
      end

      always_ff @(posedge clock) begin
         if (ce) begin
            rem_ff[j]  <= rem_in;
            root_ff[j] <= root_in;
            rad_ff[j]  <= rad_in;
            tag_ff[j]  <= tag_p;
         end
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_root  = root_ff[N-1];
   assign out_tag   = tag_ff[N-1];

endmodule
`default_nettype wire

// ===== rtl/atp_cordic_pipe.sv =====
// Pipelined vectoring rotation that accumulates atan(num / den) in degrees.
`default_nettype none
module atp_cordic_pipe (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                ce,
   input  wire                                in_valid,
   input  wire [atp_pkg::ROOT_W-1:0]          in_den,
   input  wire atp_pkg::lane_tag_type         in_tag,
   output logic                               out_valid,
   output logic signed [atp_pkg::Z_W-1:0]     out_z,
   output atp_pkg::lane_tag_type              out_tag
);

   localparam int N  = atp_pkg::CORDIC_STEPS;
   localparam int XW = atp_pkg::XY_W;
   localparam int ZW = atp_pkg::Z_W;

   logic                     valid_ff [N];
   logic signed [XW-1:0]     x_ff     [N];
   logic signed [XW-1:0]     y_ff     [N];
   logic signed [ZW-1:0]     z_ff     [N];
   atp_pkg::lane_tag_type    tag_ff   [N];

   for (genvar i = 0; i < N; i++) begin : g_stage
      logic                     valid_p;
      logic signed [XW-1:0]     x_p;
      logic signed [XW-1:0]     y_p;
      logic signed [ZW-1:0]     z_p;
      atp_pkg::lane_tag_type    tag_p;
      logic signed [XW-1:0]     x_in;
      logic signed [XW-1:0]     y_in;
      logic signed [ZW-1:0]     z_in;

      if (i == 0) begin : g_first
         assign valid_p = in_valid;
         assign x_p     = signed'({{(XW-atp_pkg::ROOT_W){1'b0}}, in_den});
         assign y_p     = signed'({{(XW-atp_pkg::SAMPLE_W-16){1'b0}}, in_tag.num_mag, 16'd0});
         assign z_p     = '0;
         assign tag_p   = in_tag;
      end else begin : g_next
         assign valid_p = valid_ff[i-1];
         assign x_p     = x_ff[i-1];
         assign y_p     = y_ff[i-1];
         assign z_p     = z_ff[i-1];
         assign tag_p   = tag_ff[i-1];
      end

      // Rotate toward the x axis; the sign of y picks the direction.
      always_comb begin
         if (!y_p[XW-1]) begin
            x_in = x_p + (y_p >>> i);
            y_in = y_p - (x_p >>> i);
            z_in = z_p + atp_pkg::ATAN_TAB[i];
         end else begin
            x_in = x_p - (y_p >>> i);
            y_in = y_p + (x_p >>> i);
            z_in = z_p - atp_pkg::ATAN_TAB[i];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (ce) begin
            valid_ff[i] <= valid_p;
         end
      end

      always_ff @(posedge clock) begin
         if (ce) begin
            x_ff[i]   <= x_in;
            y_ff[i]   <= y_in;
            z_ff[i]   <= z_in;
            tag_ff[i] <= tag_p;
         end
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_z     = z_ff[N-1];
   assign out_tag   = tag_ff[N-1];

endmodule
`default_nettype wire
